@@ src/spqc_pkg.sv @@
// Shared types and constants for the strict priority queues with cancel.
package spqc_pkg;

	localparam int NUM_QUEUES  = 4;
	localparam int MAX_OBJECTS = 256;

	localparam int OBJ_W = 8;
	localparam int Q_W   = 2;
	localparam int CNT_W = 9;
	localparam int TOT_W = CNT_W + $clog2(NUM_QUEUES);

	typedef logic [OBJ_W-1:0] obj_t;
	typedef logic [Q_W-1:0]   qid_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// request opcodes
	typedef enum logic [1:0] {
		KIND_ENQUEUE = 2'd0,
		KIND_CANCEL  = 2'd1,
		KIND_REQUEUE = 2'd2,
		KIND_DEQUEUE = 2'd3
	} kind_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_APPEND,
		ST_FINISH
	} state_t;

	// read of all link fields of one object
	typedef struct packed {
		logic en;
		obj_t addr;
	} link_rd_t;

	// link fields of one object
	typedef struct packed {
		obj_t next;
		obj_t prev;
		qid_t queue;
	} link_data_t;

	// one write per memory per cycle; node word is written by field
	typedef struct packed {
		logic next_we;
		obj_t next_addr;
		obj_t next_data;
		logic prev_we;
		logic queue_we;
		obj_t node_addr;
		obj_t prev_data;
		qid_t queue_data;
	} link_wr_t;

endpackage

@@ src/strict_priority_queues_with_cancel.sv @@
// Top level: strict priority queues of object ids with cancel, requeue and dequeue.
//
// channel  direction  handshake              payload
// req      in         req_valid / req_stall  kind, object_id, target_queue
// rsp      out        rsp_valid / rsp_stall  success, served_id, served_queue, queue_length
//
// One request at a time: each request passes the read step, then the append step for an
// enqueue or requeue that appends, then the finish step; set by the registered read of
// the link memories and one write per memory per cycle.
// A result still held by rsp_stall keeps the request waiting at the finish step.
// The result register lets the next request in while the last result waits.
// Reset clears the queued flags and queue counts; links need no clearing pass.
module strict_priority_queues_with_cancel import spqc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic [1:0]       kind,
	input  logic [OBJ_W-1:0] object_id,
	input  logic [Q_W-1:0]   target_queue,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic             success,
	output logic [OBJ_W-1:0] served_id,
	output logic [Q_W-1:0]   served_queue,
	output logic [CNT_W-1:0] queue_length
);

	state_t state_q, state_d;

	// per-queue registers and per-object queued flags
	obj_t                   head_q  [NUM_QUEUES];
	obj_t                   tail_q  [NUM_QUEUES];
	cnt_t                   count_q [NUM_QUEUES];
	logic [MAX_OBJECTS-1:0] queued_flag_q;

	// request in flight
	kind_t kind_q;
	obj_t  obj_q;
	qid_t  tq_q;
	logic  tq_ok_q;
	logic  queued_q;
	logic  success_q;
	obj_t  served_id_q;
	qid_t  served_queue_q;

	// result register
	logic  rsp_valid_q;
	logic  rsp_success_q;
	obj_t  rsp_served_id_q;
	qid_t  rsp_served_queue_q;
	cnt_t  rsp_length_q;

	link_rd_t   mem_rd;
	link_wr_t   mem_wr;
	link_data_t mem_rd_data;

	kind_t kind_in;
	logic  found;
	qid_t  sel_queue;
	obj_t  obj_sel;
	logic  tq_ok_in;
	logic  queued_in;
	logic  head_hit;
	logic  tail_hit;
	logic  do_unlink;
	logic  do_append;
	logic  tail_empty;
	obj_t  tail_t;
	logic  unlink_go;
	logic  append_go;
	logic  load_rsp;
	logic [TOT_W-1:0] cnt_total;

	spqc_link_mem u_link_mem (
		.clk     (clk),
		.rd      (mem_rd),
		.wr      (mem_wr),
		.rd_data (mem_rd_data)
	);

	// request decode and priority pick of the first non-empty queue
	always_comb begin
		kind_in   = kind_t'(kind);
		found     = 1'b0;
		sel_queue = '0;
		for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
			if (count_q[i] != '0) begin
				found     = 1'b1;
				sel_queue = Q_W'(i);
			end
		end
		obj_sel   = (kind_in == KIND_DEQUEUE) ? head_q[sel_queue] : object_id;
		tq_ok_in  = {1'b0, target_queue} < (Q_W+1)'(NUM_QUEUES);
		queued_in = (kind_in == KIND_DEQUEUE) ? found : queued_flag_q[object_id];
	end

	// unlink and append conditions
	always_comb begin
		head_hit   = head_q[mem_rd_data.queue] == obj_q;
		tail_hit   = tail_q[mem_rd_data.queue] == obj_q;
		do_unlink  = queued_q && (kind_q != KIND_ENQUEUE) &&
			((kind_q != KIND_REQUEUE) || tq_ok_q);
		do_append  = ((kind_q == KIND_ENQUEUE) && !queued_q && tq_ok_q) ||
			((kind_q == KIND_REQUEUE) && do_unlink);
		tail_t     = tail_q[tq_q];
		tail_empty = count_q[tq_q] == '0;
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and memory commands
	always_comb begin
		state_d   = state_q;
		req_stall = state_q != ST_IDLE;
		mem_rd    = '0;
		mem_wr    = '0;
		unlink_go = 1'b0;
		append_go = 1'b0;
		load_rsp  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					mem_rd.en   = 1'b1;
					mem_rd.addr = obj_sel;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				if (do_unlink) begin
					unlink_go = 1'b1;
					if (!head_hit) begin
						mem_wr.next_we   = 1'b1;
						mem_wr.next_addr = mem_rd_data.prev;
						mem_wr.next_data = mem_rd_data.next;
					end
					if (!tail_hit) begin
						mem_wr.prev_we   = 1'b1;
						mem_wr.node_addr = mem_rd_data.next;
						mem_wr.prev_data = mem_rd_data.prev;
					end
				end
				state_d = do_append ? ST_APPEND : ST_FINISH;
			end
			ST_APPEND: begin
				append_go         = 1'b1;
				mem_wr.queue_we   = 1'b1;
				mem_wr.node_addr  = obj_q;
				mem_wr.queue_data = tq_q;
				mem_wr.prev_data  = tail_t;
				if (!tail_empty) begin
					mem_wr.next_we   = 1'b1;
					mem_wr.next_addr = tail_t;
					mem_wr.next_data = obj_q;
					mem_wr.prev_we   = 1'b1;
				end
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// queued flags, counts and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queued_flag_q <= '0;
			rsp_valid_q   <= 1'b0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				count_q[i] <= '0;
			end
		end else begin
			if (unlink_go) begin
				queued_flag_q[obj_q] <= 1'b0;
				if (count_q[mem_rd_data.queue] != '0) begin
					count_q[mem_rd_data.queue] <= count_q[mem_rd_data.queue] - 1'b1;
				end
			end
			if (append_go) begin
				queued_flag_q[obj_q] <= 1'b1;
				count_q[tq_q]        <= count_q[tq_q] + 1'b1;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request fields, head and tail pointers, result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			kind_q         <= kind_in;
			obj_q          <= obj_sel;
			tq_q           <= target_queue;
			tq_ok_q        <= tq_ok_in;
			queued_q       <= queued_in;
			success_q      <= 1'b0;
			served_id_q    <= '0;
			served_queue_q <= '0;
		end
		if (unlink_go) begin
			success_q <= 1'b1;
			if (head_hit) begin
				head_q[mem_rd_data.queue] <= mem_rd_data.next;
			end
			if (tail_hit) begin
				tail_q[mem_rd_data.queue] <= mem_rd_data.prev;
			end
			if (kind_q == KIND_DEQUEUE) begin
				served_id_q    <= obj_q;
				served_queue_q <= mem_rd_data.queue;
			end
		end
		if (append_go) begin
			success_q    <= 1'b1;
			tail_q[tq_q] <= obj_q;
			if (tail_empty) begin
				head_q[tq_q] <= obj_q;
			end
		end
		if (load_rsp) begin
			rsp_success_q      <= success_q;
			rsp_served_id_q    <= served_id_q;
			rsp_served_queue_q <= served_queue_q;
			rsp_length_q       <= tq_ok_q ? count_q[tq_q] : '0;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign success      = rsp_success_q;
	assign served_id    = rsp_served_id_q;
	assign served_queue = rsp_served_queue_q;
	assign queue_length = rsp_length_q;

	// total of all queue counts
	always_comb begin
		cnt_total = '0;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			cnt_total = cnt_total + TOT_W'(count_q[i]);
		end
	end

`ifndef SYNTHESIS
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == ST_READ))
		else $error("accepted request did not start the link read");

	a_unlink_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		unlink_go |-> (count_q[mem_rd_data.queue] != '0))
		else $error("unlink from an empty queue");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		append_go |-> (count_q[tq_q] != CNT_W'(MAX_OBJECTS)))
		else $error("append to a full queue");

	a_count_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cnt_total == TOT_W'($countones(queued_flag_q))))
		else $error("queue counts disagree with queued flags");
`endif

endmodule

@@ src/spqc_link_mem.sv @@
// Link memories: next pointer, and previous pointer plus owning queue per object.
module spqc_link_mem import spqc_pkg::*; (
	input  logic       clk,
	input  link_rd_t   rd,
	input  link_wr_t   wr,
	output link_data_t rd_data
);

	typedef struct packed {
		qid_t queue;
		obj_t prev;
	} node_t;

	obj_t  next_mem [MAX_OBJECTS];
	node_t node_mem [MAX_OBJECTS];

	obj_t  next_rd_q;
	node_t node_rd_q;

	// writes; the node word takes a per-field enable
	always_ff @(posedge clk) begin
		if (wr.next_we) begin
			next_mem[wr.next_addr] <= wr.next_data;
		end
		if (wr.prev_we) begin
			node_mem[wr.node_addr].prev <= wr.prev_data;
		end
		if (wr.queue_we) begin
			node_mem[wr.node_addr].queue <= wr.queue_data;
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		if (rd.en) begin
			next_rd_q <= next_mem[rd.addr];
			node_rd_q <= node_mem[rd.addr];
		end
	end

	assign rd_data.next  = next_rd_q;
	assign rd_data.prev  = node_rd_q.prev;
	assign rd_data.queue = node_rd_q.queue;

endmodule

@@ dv/spqc_checker.sv @@
// Response checker for the strict priority queues: predicts every reply and compares it.
module spqc_checker import spqc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_stall,
	input  logic [1:0]       kind,
	input  logic [OBJ_W-1:0] object_id,
	input  logic [Q_W-1:0]   target_queue,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  logic             success,
	input  logic [OBJ_W-1:0] served_id,
	input  logic [Q_W-1:0]   served_queue,
	input  logic [CNT_W-1:0] queue_length,
	output int               fail_count,
	output int               outstanding,
	output int               checked,
	output int               peak_length
);
	timeunit 1ns;
	timeprecision 1ps;

	// home value of an object that sits in no queue
	localparam logic [2:0] NOT_QUEUED = 3'(NUM_QUEUES);

	typedef struct packed {
		logic ok;
		obj_t id;
		qid_t q;
		cnt_t len;
	} reply_t;

	// shadow of the block: queue contents in order and each object's queue
	obj_t       lists [NUM_QUEUES][$];
	logic [2:0] home [MAX_OBJECTS];
	reply_t     due_replies [$];

	int errs = 0;
	int seen = 0;
	int peak = 0;

	// take an object out of its queue, wherever it sits
	function automatic void unlink(obj_t obj);
		int q;
		int at;
		q = int'(home[obj]);
		at = 0;
		for (int i = 0; i < lists[q].size(); i++)
			if (lists[q][i] == obj)
				at = i;
		lists[q].delete(at);
		home[obj] = NOT_QUEUED;
	endfunction

	// apply one request to the shadow and return the reply it must produce
	function automatic reply_t apply_request(kind_t k, obj_t obj, qid_t tq);
		reply_t r;
		bit     tq_ok;
		r = '0;
		tq_ok = int'(tq) < NUM_QUEUES;
		case (k)
			KIND_ENQUEUE: begin
				if (tq_ok && home[obj] == NOT_QUEUED) begin
					lists[tq] = {lists[tq], obj};
					home[obj] = {1'b0, tq};
					r.ok = 1'b1;
				end
			end
			KIND_CANCEL: begin
				if (home[obj] != NOT_QUEUED) begin
					unlink(obj);
					r.ok = 1'b1;
				end
			end
			KIND_REQUEUE: begin
				if (tq_ok && home[obj] != NOT_QUEUED) begin
					unlink(obj);
					lists[tq] = {lists[tq], obj};
					home[obj] = {1'b0, tq};
					r.ok = 1'b1;
				end
			end
			default: begin
				// strict priority: lowest-numbered non-empty queue wins
				for (int q = 0; q < NUM_QUEUES; q++) begin
					if (!r.ok && lists[q].size() != 0) begin
						r.id = lists[q][0];
						lists[q].delete(0);
						home[r.id] = NOT_QUEUED;
						r.q = qid_t'(q);
						r.ok = 1'b1;
					end
				end
			end
		endcase
		r.len = tq_ok ? cnt_t'(lists[tq].size()) : '0;
		return r;
	endfunction

	function automatic void compare_field(string name, logic [CNT_W-1:0] want,
			logic [CNT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			errs++;
		end
	endfunction

	// watch both channels; replies are checked before a new request is applied
	always @(posedge clk or negedge arst_n) begin : watch
		reply_t want;
		reply_t fresh;
		if (!arst_n) begin
			foreach (home[i])
				home[i] = NOT_QUEUED;
			for (int q = 0; q < NUM_QUEUES; q++)
				lists[q].delete();
			due_replies.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				seen++;
				if (due_replies.size() == 0) begin
					$display("%0t: reply with no request waiting: expected none, %s",
						$time, "got");
					$display("    success %0d id %0d queue %0d len %0d",
						success, served_id, served_queue, queue_length);
					errs++;
				end else begin
					want = due_replies[0];
					due_replies.delete(0);
					compare_field("success", CNT_W'(want.ok), CNT_W'(success));
					compare_field("served_id", CNT_W'(want.id), CNT_W'(served_id));
					compare_field("served_queue", CNT_W'(want.q), CNT_W'(served_queue));
					compare_field("queue_length", want.len, queue_length);
				end
			end
			if (req_valid && !req_stall) begin
				fresh = apply_request(kind_t'(kind), object_id, target_queue);
				due_replies = {due_replies, fresh};
				for (int q = 0; q < NUM_QUEUES; q++)
					if (lists[q].size() > peak)
						peak = lists[q].size();
			end
		end
		fail_count  <= errs;
		outstanding <= due_replies.size();
		checked     <= seen;
		peak_length <= peak;
	end

endmodule

@@ dv/tb.sv @@
// Testbench top: drives requests and reply stalls into the queue block and gives the verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import spqc_pkg::*;

	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOT_IDS        = 24;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_stall = 1'b0;
	kind_t kind     = KIND_ENQUEUE;
	obj_t object_id = '0;
	qid_t target_queue = '0;

	logic req_stall;
	logic rsp_valid;
	logic success;
	obj_t served_id;
	qid_t served_queue;
	cnt_t queue_length;

	int fail_count;
	int outstanding;
	int checked;
	int peak_length;

	int sender_idle   = 19;
	int receiver_idle = 66;
	bit long_hold     = 1'b0;
	int sent          = 0;
	int quiet         = 0;
	obj_t hot_ids [HOT_IDS];

	strict_priority_queues_with_cancel dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.kind         (kind),
		.object_id    (object_id),
		.target_queue (target_queue),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.success      (success),
		.served_id    (served_id),
		.served_queue (served_queue),
		.queue_length (queue_length)
	);

	spqc_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.kind         (kind),
		.object_id    (object_id),
		.target_queue (target_queue),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.success      (success),
		.served_id    (served_id),
		.served_queue (served_queue),
		.queue_length (queue_length),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.checked      (checked),
		.peak_length  (peak_length)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// reply side: random stalls, plus one long hold-off on request
	initial begin : receiver
		int held;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				for (held = 0; held < HOLD_CYCLES; held++) begin
					rsp_stall <= 1'b1;
					@(negedge clk);
				end
				long_hold = 1'b0;
			end
			rsp_stall <= ($urandom_range(0, 99) < receiver_idle);
		end
	end

	// give up after a long stretch with no handshake on either side
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// offer one request after a random gap and hold it until taken
	task automatic put(kind_t k, obj_t obj, qid_t q);
		while ($urandom_range(0, 99) < sender_idle) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		kind         <= k;
		object_id    <= obj;
		target_queue <= q;
		req_valid    <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		sent++;
	endtask

	// stop offering until every reply is back
	task automatic wait_quiet();
		@(negedge clk);
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// small set of ids so cancels and requeues mostly find their object
	task automatic pick_hot_ids();
		hot_ids[0] = 8'h00;
		hot_ids[1] = 8'hFF;
		for (int i = 2; i < HOT_IDS; i++)
			hot_ids[i] = obj_t'($urandom_range(0, MAX_OBJECTS - 1));
	endtask

	task automatic random_request();
		int    r;
		kind_t k;
		obj_t  obj;
		r = $urandom_range(0, 99);
		if (r < 35)
			k = KIND_ENQUEUE;
		else if (r < 55)
			k = KIND_CANCEL;
		else if (r < 75)
			k = KIND_REQUEUE;
		else
			k = KIND_DEQUEUE;
		if ($urandom_range(0, 9) < 8)
			obj = hot_ids[$urandom_range(0, HOT_IDS - 1)];
		else
			obj = obj_t'($urandom_range(0, MAX_OBJECTS - 1));
		put(k, obj, qid_t'($urandom_range(0, NUM_QUEUES - 1)));
	endtask

	initial begin : stimulus
		obj_t order [MAX_OBJECTS];
		obj_t swap;
		int   j;
		qid_t fill_q;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty and missing cases, head/middle/tail unlinks, priority order
		put(KIND_DEQUEUE, 8'hFF, 2'd3);
		put(KIND_CANCEL,  8'h5A, 2'd1);
		put(KIND_REQUEUE, 8'h5A, 2'd2);
		put(KIND_ENQUEUE, 8'h00, 2'd3);
		put(KIND_ENQUEUE, 8'hFF, 2'd3);
		put(KIND_ENQUEUE, 8'h5A, 2'd3);
		put(KIND_ENQUEUE, 8'hA5, 2'd3);
		put(KIND_ENQUEUE, 8'hFF, 2'd0);
		put(KIND_CANCEL,  8'h5A, 2'd3);
		put(KIND_REQUEUE, 8'h00, 2'd3);
		put(KIND_ENQUEUE, 8'h3C, 2'd2);
		put(KIND_REQUEUE, 8'hA5, 2'd1);
		put(KIND_CANCEL,  8'h00, 2'd3);
		put(KIND_DEQUEUE, 8'h00, 2'd3);
		put(KIND_ENQUEUE, 8'hC3, 2'd0);
		put(KIND_DEQUEUE, 8'h00, 2'd0);
		put(KIND_CANCEL,  8'hFF, 2'd3);
		put(KIND_REQUEUE, 8'h3C, 2'd0);
		put(KIND_DEQUEUE, 8'hFF, 2'd2);
		put(KIND_DEQUEUE, 8'h00, 2'd1);
		put(KIND_CANCEL,  8'h3C, 2'd0);

		// light sender gaps, heavy reply stalls, with a full drain midway
		pick_hot_ids();
		repeat (225) random_request();
		wait_quiet();
		pick_hot_ids();
		repeat (225) random_request();
		wait_quiet();

		// heavy sender gaps, light reply stalls
		sender_idle   = 66;
		receiver_idle = 19;
		pick_hot_ids();
		repeat (450) random_request();
		wait_quiet();

		// full speed: clear everything, then fill one queue to the top
		sender_idle   = 0;
		receiver_idle = 0;
		for (int i = 0; i < MAX_OBJECTS; i++)
			order[i] = obj_t'(i);
		for (int i = MAX_OBJECTS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			swap = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		for (int i = 0; i < MAX_OBJECTS; i++)
			put(KIND_CANCEL, order[i], qid_t'($urandom_range(0, NUM_QUEUES - 1)));
		fill_q = qid_t'($urandom_range(0, NUM_QUEUES - 1));
		// replies held off while the block keeps being offered requests
		long_hold = 1'b1;
		for (int i = MAX_OBJECTS - 1; i >= 0; i--)
			put(KIND_ENQUEUE, order[i], fill_q);
		pick_hot_ids();
		repeat (150) random_request();
		// serve everything out, ending on dequeues from empty queues
		repeat (MAX_OBJECTS + 4)
			put(KIND_DEQUEUE, obj_t'($urandom_range(0, MAX_OBJECTS - 1)),
				qid_t'($urandom_range(0, NUM_QUEUES - 1)));
		wait_quiet();
		repeat (10) @(posedge clk);

		$display("Covered %0d requests (%0d replies checked) under three stall mixes,",
			sent, checked);
		$display("a %0d-cycle reply hold-off and queues up to %0d deep.",
			HOLD_CYCLES, peak_length);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
